FILE: hw/rtl/cpif_pkg.sv
// Package for the coprime pair index filter: widths, stream packing constants
// and the command and status structs between controller and datapath.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package cpif_pkg;

  // Operand and index widths of the block.
  localparam int VALUE_BITS     = 31;
  localparam int INDEX_BITS     = 16;
  localparam int OUT_INDEX_BITS = 16;

  // Stream data widths, padded to whole bytes.
  localparam int S_DATA_BITS = ((2 * VALUE_BITS + 7) / 8) * 8;
  localparam int M_DATA_BITS = ((OUT_INDEX_BITS + 1 + 7) / 8) * 8;

  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [INDEX_BITS-1:0] index_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;   // capture a new pair and its index
    logic step;      // one reduction step of the binary GCD
    logic load_out;  // copy the verdict into the output register
  } cpif_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic done;      // the reduction has reached its verdict
  } cpif_status_t;

endpackage : cpif_pkg

`default_nettype wire

FILE: hw/rtl/cpif_ctrl.sv
// Controller of the coprime pair index filter: accepts one pair at a time,
// drives the reduction steps and owns the output valid flag.
// Depends on cpif_pkg for the command and status structs.
`default_nettype none

module cpif_ctrl
  import cpif_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  input  wire cpif_status_t status,
  output cpif_cmd_t         cmd
);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  state_t state;
  logic   out_free;

  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    cmd          = '0;
    cmd.load_in  = (state == ST_IDLE) && s_tvalid;
    cmd.step     = (state == ST_RUN) && !status.done;
    cmd.load_out = (state == ST_RUN) && status.done && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) state <= ST_RUN;
        end
        ST_RUN: begin
          if (status.done && out_free) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase

      if (cmd.load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule : cpif_ctrl

`default_nettype wire

FILE: hw/rtl/cpif_datapath.sv
// Datapath of the coprime pair index filter: operand registers with a binary
// GCD reduction step, the element counter and the output register.
// Depends on cpif_pkg for widths and the command and status structs.
`default_nettype none

module cpif_datapath
  import cpif_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire cpif_cmd_t                 cmd,
  output cpif_status_t                   status,
  input  wire value_t                    in_a,
  input  wire value_t                    in_b,
  input  wire logic                      in_last,
  output logic [OUT_INDEX_BITS-1:0]      pair_index,
  output logic                           coprime,
  output logic                           last_out
);

  value_t op_a;
  value_t op_b;
  index_t cur_index;
  logic   cur_last;
  index_t element_counter;

  value_t          op_a_next;
  value_t          op_b_next;
  logic [VALUE_BITS:0] diff_ab;
  value_t          diff_ba;
  logic            a_zero;
  logic            b_zero;
  logic            verdict;

  assign a_zero = (op_a == '0);
  assign b_zero = (op_b == '0);

  // Once one operand is zero the other is the GCD. Both even means a factor
  // of two is shared, which can only happen on the loaded pair itself.
  assign status.done = a_zero || b_zero || (!op_a[0] && !op_b[0]);
  assign verdict     = (a_zero && (op_b == value_t'(1))) ||
                       (b_zero && (op_a == value_t'(1)));

  assign diff_ab = {1'b0, op_a} - {1'b0, op_b};
  assign diff_ba = op_b - op_a;

  // One step: strip a factor of two from an even operand, or replace the
  // larger odd operand by half the difference, which is always even.
  always_comb begin
    op_a_next = op_a;
    op_b_next = op_b;
    priority if (!op_a[0]) begin
      op_a_next = op_a >> 1;
    end else if (!op_b[0]) begin
      op_b_next = op_b >> 1;
    end else if (!diff_ab[VALUE_BITS]) begin
      op_a_next = diff_ab[VALUE_BITS:1];
    end else begin
      op_b_next = diff_ba >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      element_counter <= '0;
    end else if (cmd.load_in) begin
      element_counter <= in_last ? '0 : element_counter + index_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_a      <= in_a;
      op_b      <= in_b;
      cur_index <= element_counter;
      cur_last  <= in_last;
    end else if (cmd.step) begin
      op_a <= op_a_next;
      op_b <= op_b_next;
    end

    if (cmd.load_out) begin
      pair_index <= OUT_INDEX_BITS'(cur_index);
      coprime    <= verdict;
      last_out   <= cur_last;
    end
  end

endmodule : cpif_datapath

`default_nettype wire

FILE: hw/rtl/coprime_pair_index_filter_top.sv
// Top level of the coprime pair index filter: stream ports, the controller
// and the datapath. Depends on cpif_pkg, cpif_ctrl and cpif_datapath.
//
// Use: pairs of values arrive on the slave stream (s_*). Each transaction
// carries value_a and value_b in s_tdata and the last-of-frame mark in
// s_tlast. For every pair exactly one result transaction leaves on the
// master stream (m_*): the pair's index within its frame and a flag that is
// set when the greatest common divisor of the pair is one; m_tlast copies the
// input mark. The index starts again at zero after a pair marked last and
// wraps at its width otherwise.
// Timing: one pair is worked on at a time. The block uses the binary form of
// Euclid's algorithm in an iterative unit, one reduction step per cycle; a
// pair needs k steps, 0 <= k <= 2*VALUE_BITS-1 (61), set by the bit lengths
// of its operands. The result register is loaded once the steps are done
// and the output register is free; m_tvalid rises and s_tready returns in
// that same cycle, so the next pair is taken only after the previous
// result has been loaded.
// The output register lets the next pair be accepted and reduced while a
// result still waits; if the receiver stalls, the finished verdict waits in
// the unit and no further pair is taken until the output register frees.
// Reset (rst, synchronous, active high) empties both streams, returns the
// controller to idle and clears the element counter.
`default_nettype none

module coprime_pair_index_filter_top
  import cpif_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  // s_tdata, from bit 0: value_a [30:0], value_b [61:31], zero padding.
  input  wire logic [S_DATA_BITS-1:0] s_tdata,
  input  wire logic                   s_tlast,
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  // m_tdata, from bit 0: pair_index [15:0], coprime [16], zero padding.
  output logic [M_DATA_BITS-1:0]      m_tdata,
  output logic                        m_tlast
);

  cpif_cmd_t                 cmd;
  cpif_status_t              status;
  logic [OUT_INDEX_BITS-1:0] pair_index;
  logic                      coprime;

  cpif_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  cpif_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .in_a       (s_tdata[VALUE_BITS-1:0]),
    .in_b       (s_tdata[2*VALUE_BITS-1:VALUE_BITS]),
    .in_last    (s_tlast),
    .pair_index (pair_index),
    .coprime    (coprime),
    .last_out   (m_tlast)
  );

  assign m_tdata = M_DATA_BITS'({coprime, pair_index});

  // Only one pair is in the unit: after a transaction the input is closed.
  a_one_in_flight : assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted while a pair is still being reduced");

  // A verdict is written only once the reduction has finished.
  a_load_when_done : assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> status.done)
    else $error("result loaded before the reduction finished");

  // A waiting result is never overwritten.
  a_no_overwrite : assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!m_tvalid || m_tready))
    else $error("result register overwritten while still waiting");

  // Reduction steps and a new load never coincide.
  a_step_exclusive : assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> !cmd.load_in && !cmd.load_out)
    else $error("reduction step overlaps a load");

endmodule : coprime_pair_index_filter_top

`default_nettype wire

FILE: bench/testbench.sv
// Self-checking testbench for coprime_pair_index_filter_top: drives pairs on the
// slave stream, predicts each verdict and compares it with the master stream.
// Depends on cpif_pkg and the block's RTL only.

module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import cpif_pkg::*;

  localparam int CLK_HALF     = 4;
  localparam int RESET_CYCLES = 5;
  // The quiet-cycle limit covers the reduction of one pair and leaves room
  // for long runs of random stalls on either side.
  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 100;
  localparam int RANDOM_PAIRS = 1130;
  localparam value_t TOP_OPERAND = '1;

  // One expected result: the fields of m_tdata and m_tlast.
  typedef struct packed {
    logic [OUT_INDEX_BITS-1:0] pair_index;
    logic                      coprime;
    logic                      last_out;
  } verdict_t;

  // Holds the block's index counter and the verdicts still to come out.
  class coprime_scoreboard;
    index_t   next_index;
    verdict_t awaited_verdicts[$];
    int       errors;

    function new();
      next_index = '0;
      errors     = 0;
    endfunction

    // Repeated remainder; a zero operand leaves the other value as the divisor.
    function bit gcd_is_one(longint unsigned x, longint unsigned y);
      longint unsigned r;
      while (y != 0) begin
        r = x % y;
        x = y;
        y = r;
      end
      return x == 1;
    endfunction

    task report_mismatch(string what);
      errors++;
      $display("%0t ns ERROR: %s", $time, what);
    endtask

    function void note_pair(value_t a, value_t b, logic last);
      verdict_t v;
      v.pair_index = next_index[OUT_INDEX_BITS-1:0];
      v.coprime    = gcd_is_one(a, b);
      v.last_out   = last;
      awaited_verdicts = {awaited_verdicts, v};
      next_index = last ? '0 : index_t'(next_index + 1'b1);
    endfunction

    task check_verdict(logic [M_DATA_BITS-1:0] data, logic last);
      verdict_t want;
      if (awaited_verdicts.size() == 0) begin
        report_mismatch($sformatf("result with no pair pending, tdata=%h tlast=%b",
                                  data, last));
        return;
      end
      want = awaited_verdicts.pop_front();
      if (data[OUT_INDEX_BITS-1:0] !== want.pair_index) begin
        report_mismatch($sformatf("pair_index %0d, expected %0d",
                                  data[OUT_INDEX_BITS-1:0], want.pair_index));
      end
      if (data[OUT_INDEX_BITS] !== want.coprime) begin
        report_mismatch($sformatf("coprime %b, expected %b at index %0d",
                                  data[OUT_INDEX_BITS], want.coprime, want.pair_index));
      end
      if (last !== want.last_out) begin
        report_mismatch($sformatf("last_out %b, expected %b at index %0d",
                                  last, want.last_out, want.pair_index));
      end
    endtask

    function int pending();
      return awaited_verdicts.size();
    endfunction

    task flag_leftovers();
      if (awaited_verdicts.size() != 0) begin
        report_mismatch($sformatf("%0d results never arrived", awaited_verdicts.size()));
      end
    endtask
  endclass

  logic                   clk      = 1'b0;
  logic                   rst      = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [S_DATA_BITS-1:0] s_tdata  = '0;
  logic                   s_tlast  = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [M_DATA_BITS-1:0] m_tdata;
  logic                   m_tlast;

  coprime_scoreboard sb;
  // Chance, in per cent, that the sender holds back or the receiver stalls
  // in a given cycle.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  // Cycles in a row in which neither stream completed a transaction.
  int quiet_cycles  = 0;

  coprime_pair_index_filter_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // Presents one pair and waits until the block takes it. A random gap of
  // idle cycles may come first; tvalid is lowered only when such a gap is
  // taken, so back-to-back pairs keep it high without a glitch. The
  // expectation is noted at the edge of the transaction, which always comes
  // before the result can be accepted.
  task automatic send_pair(input value_t a, input value_t b, input logic last);
    logic [S_DATA_BITS-1:0] word;
    word = '0;
    word[VALUE_BITS-1:0]            = a;
    word[2*VALUE_BITS-1:VALUE_BITS] = b;
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    s_tlast  <= last;
    do @(posedge clk); while (s_tready !== 1'b1);
    sb.note_pair(a, b, last);
  endtask

  // Hand-picked pairs: the extremes of both operands, zero operands, equal
  // and neighbouring values, powers of two, the slowest case of Euclid's
  // algorithm (consecutive Fibonacci numbers) and short frames.
  task automatic run_directed();
    send_pair(1, 1, 1'b0);
    send_pair(0, 0, 1'b0);
    send_pair(0, 1, 1'b0);
    send_pair(1, 0, 1'b0);
    send_pair(0, 7, 1'b0);
    send_pair(9, 0, 1'b1);
    send_pair(TOP_OPERAND, TOP_OPERAND, 1'b1);
    send_pair(TOP_OPERAND, 1, 1'b0);
    send_pair(1, TOP_OPERAND, 1'b0);
    send_pair(TOP_OPERAND, TOP_OPERAND - 1, 1'b0);
    send_pair(TOP_OPERAND - 1, 31'h3fff_ffff, 1'b0);
    send_pair(31'h4000_0000, 31'h2000_0000, 1'b0);
    send_pair(31'h4000_0000, 1, 1'b0);
    send_pair(31'd1836311903, 31'd1134903170, 1'b0);
    send_pair(31'd1134903170, 31'd1836311903, 1'b0);
    send_pair(31'h5555_5555, 31'h2aaa_aaaa, 1'b0);
    send_pair(31'd196611, 31'd327685, 1'b0);
    send_pair(6, 4, 1'b0);
    send_pair(12, 18, 1'b1);
    send_pair(2, 3, 1'b1);
    send_pair(31'd2147483629, 31'd2147483587, 1'b1);
  endtask

  // Random pairs of several kinds, so that both verdicts are common and the
  // reduction runs for short as well as long counts of steps.
  task automatic run_random(input int count);
    value_t      a, b, t;
    int unsigned g;
    int          kind;
    for (int n = 0; n < count; n++) begin
      kind = $urandom_range(99);
      if (kind < 30) begin
        a = value_t'($urandom_range(1, TOP_OPERAND));
        b = value_t'($urandom_range(1, TOP_OPERAND));
      end else if (kind < 50) begin
        // A shared factor always makes the pair non-coprime.
        g = $urandom_range(2, 1000);
        a = value_t'(g * $urandom_range(1, 2000000));
        b = value_t'(g * $urandom_range(1, 2000000));
      end else if (kind < 70) begin
        a = value_t'($urandom_range(1, 64));
        b = value_t'($urandom_range(1, 64));
      end else if (kind < 85) begin
        a = value_t'(1) << $urandom_range(0, VALUE_BITS - 1);
        b = value_t'($urandom_range(1, TOP_OPERAND));
      end else begin
        // Neighbours are always coprime; equal values only when both are one.
        a = value_t'($urandom_range(1, TOP_OPERAND - 1));
        b = $urandom_range(1) ? value_t'(a + 1'b1) : a;
      end
      if ($urandom_range(1)) begin
        t = a;
        a = b;
        b = t;
      end
      send_pair(a, b, $urandom_range(9) == 0);
    end
  endtask

  // Receiver: checks every result transaction, keeps the quiet-cycle count
  // and draws tready for the next cycle.
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid === 1'b1 && m_tready) begin
        sb.check_verdict(m_tdata, m_tlast);
      end
      if ((s_tvalid && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: a run in which nothing moves for too long has hung.
  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("coprime_pair_index_filter_top: mismatch");
    $finish;
  end

  // Main sequence: reset, the hand-picked pairs, then random pairs under
  // three stall patterns (sender mostly ready, then receiver mostly ready,
  // then neither stalling).
  initial begin
    sb = new();
    send_idle_pct = 27;
    recv_idle_pct = 76;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    run_random(RANDOM_PAIRS / 3);
    send_idle_pct = 76;
    recv_idle_pct = 27;
    run_random(RANDOM_PAIRS / 3);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(RANDOM_PAIRS - 2 * (RANDOM_PAIRS / 3));
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    // Any stray result would surface within the block's latency.
    repeat (DRAIN_CYCLES) @(posedge clk);
    sb.flag_leftovers();
    if (sb.errors == 0) begin
      $display("coprime_pair_index_filter_top: match");
    end else begin
      $display("coprime_pair_index_filter_top: mismatch");
    end
    $finish;
  end

endmodule
